// ===== hdl/dtlsrf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtlsrf_pkg
// Shared types and constants for the DTLS record framing checker.
// ----------------------------------------------------------------------------
`default_nettype none

package dtlsrf_pkg;

  // Header byte values
  localparam logic [7:0] TYPE_HANDSHAKE = 8'h16;
  localparam logic [7:0] TYPE_CCS       = 8'h14;
  localparam logic [7:0] VER_MAJOR      = 8'hfe;
  localparam logic [7:0] VER_MINOR_A    = 8'hff;
  localparam logic [7:0] VER_MINOR_B    = 8'hfd;

  // Header byte positions
  localparam logic [4:0] HDR_IDX_TYPE   = 5'd0;
  localparam logic [4:0] HDR_IDX_VMAJ   = 5'd1;
  localparam logic [4:0] HDR_IDX_VMIN   = 5'd2;
  localparam logic [4:0] HDR_IDX_LEN_HI = 5'd11;
  localparam logic [4:0] HDR_IDX_LEN_LO = 5'd12;

  localparam logic [15:0] HDR_BYTES     = 16'd13;
  localparam logic [24:0] HS_HDR_BYTES  = 25'd12;
  localparam logic [15:0] HS_MIN_BODY   = 16'd4;
  localparam logic [15:0] POS_MAX       = 16'hffff;

  // Result kinds
  localparam logic KIND_DESC    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    VERD_KEEP     = 2'd0,
    VERD_CCS      = 2'd1,
    VERD_NOT_DTLS = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [1:0]  verdict;
    logic        last;
  } result_t;

  // Results produced by one byte: count is 0, 1 or 2; r0 goes out first.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } step_out_t;

  // Result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef struct packed {
    logic [OQ_CW-1:0] count;
    logic             no_room;
  } oq_status_t;

endpackage

`default_nettype wire

// ===== hdl/dtls_record_framing_check.sv =====
// ----------------------------------------------------------------------------
// dtls_record_framing_check
// Splits a UDP payload, one byte per transfer, into DTLS records; emits a
// descriptor per valid handshake record and a verdict at the last byte.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | in_valid / in_stall    | data_byte, end_of_packet
//  out     | output    | out_valid / out_stall  | result_kind, record_offset,
//          |           |                        | record_length, verdict, last_result
//
//  One byte per cycle while in_stall is low: each byte is parsed in a single pass
//  against the packet state registers and its results go into a 4-entry result queue.
//  A byte's results are registered into the queue at its transfer and are offered
//  once the results ahead of them have gone out. in_stall rises while fewer
//  than two queue slots are free, so any accepted byte finds room for its results.
//  Synchronous reset returns to the start of a packet with the queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module dtls_record_framing_check
  import dtlsrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_packet,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [15:0]      record_offset,
  output logic [15:0]      record_length,
  output logic [1:0]       verdict,
  output logic             last_result
);

  logic       in_xfer;
  step_out_t  step;
  result_t    head;
  oq_status_t q_status;

  assign in_stall = q_status.no_room;
  assign in_xfer  = in_valid && !in_stall;

  dtlsrf_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_xfer),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .step          (step)
  );

  dtlsrf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (in_xfer),
    .step      (step),
    .pop       (!out_stall),
    .out_valid (out_valid),
    .head      (head),
    .status    (q_status)
  );

  assign result_kind   = head.kind;
  assign record_offset = head.offset;
  assign record_length = head.length;
  assign verdict       = head.verdict;
  assign last_result   = head.last;

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= OQ_CW'(OQ_DEPTH))
    else $error("result queue count beyond depth");

  // two results from one byte: descriptor first, then verdict
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && step.count == 2'd2) |->
      (step.r0.kind == KIND_DESC && step.r1.kind == KIND_VERDICT))
    else $error("bad result order for one byte");

  // a verdict always closes the results of its byte
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_VERDICT) |-> last_result)
    else $error("verdict not marked last");

  // descriptors only with a body of at least HS_MIN_BODY bytes and a keep verdict
  a_desc_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_DESC) |->
      (record_length >= HS_MIN_BODY && verdict == VERD_KEEP))
    else $error("descriptor with short body or nonzero verdict");

endmodule

`default_nettype wire

// ===== hdl/dtlsrf_parse.sv =====
// ----------------------------------------------------------------------------
// dtlsrf_parse
// Per-packet record parser: packet state registers and the single-pass
// update for one payload byte, with the results that byte produces.
// ----------------------------------------------------------------------------
`default_nettype none

module dtlsrf_parse
  import dtlsrf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_packet,
  output step_out_t       step
);

  phase_t      phase,     phase_next;
  logic [15:0] pos,       pos_next;
  logic [4:0]  hidx,      hidx_next;
  logic        is_hs,     is_hs_next;
  logic [15:0] blen,      blen_next;
  logic [23:0] hml,       hml_next;
  logic [15:0] rstart,    rstart_next;
  verdict_t    verd,      verd_next;

  logic [15:0] body_k;
  logic [23:0] hml_upd;
  logic [15:0] len_lo;
  logic        desc_fire;
  logic [1:0]  eop_verd;
  result_t     desc_res;
  result_t     verd_res;

  always_comb begin
    phase_next  = phase;
    pos_next    = pos;
    hidx_next   = hidx;
    is_hs_next  = is_hs;
    blen_next   = blen;
    hml_next    = hml;
    rstart_next = rstart;
    verd_next   = verd;
    desc_fire   = 1'b0;
    body_k      = pos - rstart - HDR_BYTES;
    hml_upd     = hml;
    len_lo      = {blen[15:8], data_byte};

    if (pos == POS_MAX) begin
      // oversized packet overrides everything, including a change-cipher verdict
      phase_next = PH_DONE;
      verd_next  = VERD_NOT_DTLS;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          hidx_next = hidx + 5'd1;
          case (hidx)
            HDR_IDX_TYPE: begin
              if (data_byte != TYPE_HANDSHAKE && data_byte != TYPE_CCS) begin
                phase_next = PH_DONE;
                verd_next  = VERD_NOT_DTLS;
                hidx_next  = hidx;
              end else begin
                is_hs_next  = (data_byte == TYPE_HANDSHAKE);
                rstart_next = pos;
              end
            end
            HDR_IDX_VMAJ: begin
              if (data_byte != VER_MAJOR) begin
                phase_next = PH_DONE;
                verd_next  = VERD_NOT_DTLS;
                hidx_next  = hidx;
              end
            end
            HDR_IDX_VMIN: begin
              if (data_byte != VER_MINOR_A && data_byte != VER_MINOR_B) begin
                phase_next = PH_DONE;
                verd_next  = VERD_NOT_DTLS;
                hidx_next  = hidx;
              end
            end
            HDR_IDX_LEN_HI: begin
              blen_next = {data_byte, 8'h00};
            end
            HDR_IDX_LEN_LO: begin
              blen_next = len_lo;
              if (len_lo == 16'd0) begin
                phase_next = PH_DONE;
                verd_next  = VERD_NOT_DTLS;
                hidx_next  = hidx;
              end else begin
                hml_next   = 24'd0;
                hidx_next  = 5'd0;
                phase_next = PH_BODY;
              end
            end
            default: ;
          endcase
        end
        PH_BODY: begin
          // body bytes 1..3 carry the handshake message length
          if (body_k >= 16'd1 && body_k <= 16'd3) begin
            hml_upd = {hml[15:0], data_byte};
          end
          hml_next = hml_upd;
          if (({1'b0, body_k} + 17'd1) >= {1'b0, blen}) begin
            if (!is_hs) begin
              phase_next = PH_DONE;
              verd_next  = VERD_CCS;
            end else if (blen < HS_MIN_BODY ||
                         ({1'b0, hml_upd} + HS_HDR_BYTES) != {9'd0, blen}) begin
              phase_next = PH_DONE;
              verd_next  = VERD_NOT_DTLS;
            end else begin
              desc_fire  = 1'b1;
              phase_next = PH_HEADER;
              hidx_next  = 5'd0;
            end
          end
        end
        default: ;
      endcase
    end

    if (pos != POS_MAX) begin
      pos_next = pos + 16'd1;
    end

    // verdict from the state left by this byte
    if (phase_next == PH_HEADER) begin
      eop_verd = (hidx_next == 5'd0) ? VERD_KEEP : VERD_NOT_DTLS;
    end else if (phase_next == PH_BODY) begin
      eop_verd = VERD_NOT_DTLS;
    end else begin
      eop_verd = verd_next;
    end

    if (end_of_packet) begin
      phase_next  = PH_HEADER;
      pos_next    = 16'd0;
      hidx_next   = 5'd0;
      is_hs_next  = 1'b0;
      blen_next   = 16'd0;
      hml_next    = 24'd0;
      rstart_next = 16'd0;
      verd_next   = VERD_KEEP;
    end
  end

  always_comb begin
    desc_res.kind    = KIND_DESC;
    desc_res.offset  = rstart + HDR_BYTES;
    desc_res.length  = blen;
    desc_res.verdict = VERD_KEEP;
    desc_res.last    = !end_of_packet;

    verd_res.kind    = KIND_VERDICT;
    verd_res.offset  = 16'd0;
    verd_res.length  = 16'd0;
    verd_res.verdict = eop_verd;
    verd_res.last    = 1'b1;

    step.r1 = verd_res;
    if (desc_fire) begin
      step.r0    = desc_res;
      step.count = end_of_packet ? 2'd2 : 2'd1;
    end else begin
      step.r0    = verd_res;
      step.count = end_of_packet ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEADER;
      pos    <= 16'd0;
      hidx   <= 5'd0;
      is_hs  <= 1'b0;
      blen   <= 16'd0;
      hml    <= 24'd0;
      rstart <= 16'd0;
      verd   <= VERD_KEEP;
    end else if (accept) begin
      phase  <= phase_next;
      pos    <= pos_next;
      hidx   <= hidx_next;
      is_hs  <= is_hs_next;
      blen   <= blen_next;
      hml    <= hml_next;
      rstart <= rstart_next;
      verd   <= verd_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dtlsrf_outq.sv =====
// ----------------------------------------------------------------------------
// dtlsrf_outq
// Small result queue: takes up to two results per cycle, hands out one per
// transfer. Reports no_room while fewer than two slots are free.
// ----------------------------------------------------------------------------
`default_nettype none

module dtlsrf_outq
  import dtlsrf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire step_out_t step,
  input  wire logic      pop,
  output logic           out_valid,
  output result_t        head,
  output oq_status_t     status
);

  result_t          mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_CW-1:0] count;
  logic [OQ_CW-1:0] push_n;
  logic             pop_q;

  assign push_n    = push ? {{(OQ_CW-2){1'b0}}, step.count} : '0;
  assign pop_q     = pop && (count != '0);
  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];

  assign status.count   = count;
  assign status.no_room = (count > OQ_CW'(OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push && step.count != 2'd0) begin
      mem[wr_ptr] <= step.r0;
    end
    if (push && step.count == 2'd2) begin
      mem[wr_ptr + OQ_AW'(1)] <= step.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[OQ_AW-1:0];
      if (pop_q) begin
        rd_ptr <= rd_ptr + OQ_AW'(1);
      end
      count <= count + push_n - {{(OQ_CW-1){1'b0}}, pop_q};
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_dtls_record_framing_check.sv =====
// ----------------------------------------------------------------------------
// tb_dtls_record_framing_check
// Self-checking bench for the DTLS record framing checker. Packets are built
// from well-formed handshake and change-cipher records, broken headers, cut
// records and noise, then sent one byte per transfer with random gaps. A
// scoreboard tracks the per-packet parse state and predicts every descriptor
// and verdict, which are checked in order against the output channel.
// ----------------------------------------------------------------------------

module tb_dtls_record_framing_check;
  import dtlsrf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_BYTES   = 1600;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 20;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow parse state plus the queue of results still due
  // --------------------------------------------------------------------------
  class framing_scoreboard;
    phase_t       phase;
    logic [15:0]  pos;
    logic [4:0]   hidx;
    logic         is_hs;
    logic [15:0]  body_len;
    logic [23:0]  msg_len;
    logic [15:0]  rec_start;
    verdict_t     pkt_verd;
    result_t      pending_results[$];
    int unsigned  errors;
    int unsigned  checked;

    function new();
      reset_state();
      errors  = 0;
      checked = 0;
    endfunction

    function void reset_state();
      phase     = PH_HEADER;
      pos       = '0;
      hidx      = '0;
      is_hs     = 1'b0;
      body_len  = '0;
      msg_len   = '0;
      rec_start = '0;
      pkt_verd  = VERD_KEEP;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void abort_packet(verdict_t v);
      phase    = PH_DONE;
      pkt_verd = v;
    endfunction

    function void take_header_byte(logic [7:0] b);
      case (hidx)
        HDR_IDX_TYPE: begin
          if (b != TYPE_HANDSHAKE && b != TYPE_CCS) begin
            abort_packet(VERD_NOT_DTLS);
            return;
          end
          is_hs     = (b == TYPE_HANDSHAKE);
          rec_start = pos;
        end
        HDR_IDX_VMAJ: begin
          if (b != VER_MAJOR) begin
            abort_packet(VERD_NOT_DTLS);
            return;
          end
        end
        HDR_IDX_VMIN: begin
          if (b != VER_MINOR_A && b != VER_MINOR_B) begin
            abort_packet(VERD_NOT_DTLS);
            return;
          end
        end
        HDR_IDX_LEN_HI: body_len = {b, 8'h00};
        HDR_IDX_LEN_LO: begin
          body_len = {body_len[15:8], b};
          if (body_len == 16'd0) begin
            abort_packet(VERD_NOT_DTLS);
          end else begin
            msg_len = '0;
            hidx    = '0;
            phase   = PH_BODY;
          end
          return;
        end
        default: ;
      endcase
      hidx = hidx + 5'd1;
    endfunction

    // One accepted byte: advance the shadow state, queue what it causes
    function void note_byte(logic [7:0] b, logic eop);
      result_t     outs[$];
      result_t     r;
      logic [15:0] k;
      int unsigned ku;
      if (pos >= POS_MAX) begin
        abort_packet(VERD_NOT_DTLS);
      end else if (phase == PH_HEADER) begin
        take_header_byte(b);
      end else if (phase == PH_BODY) begin
        k  = pos - rec_start - HDR_BYTES;
        ku = k;
        if (ku >= 1 && ku <= 3) msg_len = {msg_len[15:0], b};
        if (ku + 1 >= int'(body_len)) begin
          if (!is_hs) begin
            abort_packet(VERD_CCS);
          end else if (body_len < HS_MIN_BODY ||
                       int'(msg_len) + 12 != int'(body_len)) begin
            abort_packet(VERD_NOT_DTLS);
          end else begin
            r.kind    = KIND_DESC;
            r.offset  = rec_start + HDR_BYTES;
            r.length  = body_len;
            r.verdict = VERD_KEEP;
            r.last    = 1'b0;
            outs.push_back(r);
            phase = PH_HEADER;
            hidx  = '0;
          end
        end
      end

      if (pos < POS_MAX) pos = pos + 16'd1;

      if (eop) begin
        r.kind   = KIND_VERDICT;
        r.offset = '0;
        r.length = '0;
        r.last   = 1'b0;
        if (phase == PH_HEADER)
          r.verdict = (hidx == 5'd0) ? VERD_KEEP : VERD_NOT_DTLS;
        else if (phase == PH_BODY)
          r.verdict = VERD_NOT_DTLS;
        else
          r.verdict = pkt_verd;
        outs.push_back(r);
        reset_state();
      end

      if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
      foreach (outs[i]) pending_results.push_back(outs[i]);
    endfunction

    task check_result(logic kind, logic [15:0] offset, logic [15:0] length,
                      logic [1:0] verd, logic last);
      result_t got;
      result_t want;
      got = '{kind: kind, offset: offset, length: length, verdict: verd, last: last};
      checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing due: kind %0d off %0d len %0d verd %0d",
                         checked, kind, offset, length, verd));
        return;
      end
      want = pending_results.pop_front();
      if (got !== want)
        report($sformatf({"result %0d: got kind %0d off %0d len %0d verd %0d last %0d, ",
                          "want kind %0d off %0d len %0d verd %0d last %0d"},
                         checked, got.kind, got.offset, got.length, got.verdict, got.last,
                         want.kind, want.offset, want.length, want.verdict, want.last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        result_kind;
  logic [15:0] record_offset;
  logic [15:0] record_length;
  logic [1:0]  verdict;
  logic        last_result;

  always #5 clk = ~clk;

  dtls_record_framing_check i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .record_offset (record_offset),
    .record_length (record_length),
    .verdict       (verdict),
    .last_result   (last_result)
  );

  framing_scoreboard scb;
  int unsigned       idle_pct  = 22;
  int unsigned       stall_pct = 22;
  bit                hold_req  = 1'b0;
  int unsigned       quiet_cycles = 0;
  int unsigned       sent_bytes = 0;
  logic [7:0]        pkt[$];

  // Both channels sampled in one process so prediction precedes checking
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) scb.note_byte(data_byte, end_of_packet);
      if (out_valid && !out_stall)
        scb.check_result(result_kind, record_offset, record_length, verdict, last_result);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or one long hold-off when asked
  initial begin : receiver
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (n = 1; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Packet building and sending
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_minor();
    return $urandom_range(1) ? VER_MINOR_A : VER_MINOR_B;
  endfunction

  task automatic add_header(logic [7:0] typ, logic [7:0] vmaj, logic [7:0] vmin,
                            logic [15:0] len);
    int i;
    pkt.push_back(typ);
    pkt.push_back(vmaj);
    pkt.push_back(vmin);
    for (i = 3; i < 11; i++) pkt.push_back(rand_byte());
    pkt.push_back(len[15:8]);
    pkt.push_back(len[7:0]);
  endtask

  // Handshake body: bytes 1..3 carry the message length
  task automatic add_hs_body(int unsigned len, logic [23:0] mlen);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      case (i)
        1:       pkt.push_back(mlen[23:16]);
        2:       pkt.push_back(mlen[15:8]);
        3:       pkt.push_back(mlen[7:0]);
        default: pkt.push_back(rand_byte());
      endcase
    end
  endtask

  task automatic add_noise(int unsigned n);
    repeat (n) pkt.push_back(rand_byte());
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_packet <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_pkt();
    int unsigned i;
    for (i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    sent_bytes += pkt.size();
    pkt.delete();
  endtask

  // Mostly well-formed records with random content; the rest broken or noise
  task automatic gen_packet();
    int unsigned nrec;
    int unsigned c;
    int unsigned body;
    int unsigned n;
    logic [23:0] m;
    nrec = $urandom_range(1, 4);
    repeat (nrec) begin
      c = $urandom_range(99);
      if (c < 60) begin
        body = $urandom_range(12, 40);
        m    = 24'(body - 12);
        add_header(TYPE_HANDSHAKE, VER_MAJOR, pick_minor(), 16'(body));
        add_hs_body(body, m);
      end else if (c < 72) begin
        body = $urandom_range(1, 6);
        add_header(TYPE_CCS, VER_MAJOR, pick_minor(), 16'(body));
        add_noise(body);
      end else if (c < 76) begin
        body = $urandom_range(4, 40);
        m    = 24'($urandom_range(24'hffffff));
        add_header(TYPE_HANDSHAKE, VER_MAJOR, pick_minor(), 16'(body));
        add_hs_body(body, m);
      end else if (c < 79) begin
        body = $urandom_range(1, 3);
        add_header(TYPE_HANDSHAKE, VER_MAJOR, pick_minor(), 16'(body));
        add_hs_body(body, 24'd0);
      end else if (c < 82) begin
        add_header(rand_byte(), VER_MAJOR, pick_minor(), 16'($urandom_range(1, 20)));
        add_noise($urandom_range(0, 20));
      end else if (c < 85) begin
        if ($urandom_range(1))
          add_header(TYPE_HANDSHAKE, rand_byte(), pick_minor(), 16'd12);
        else
          add_header(TYPE_CCS, VER_MAJOR, rand_byte(), 16'd1);
        add_noise($urandom_range(0, 12));
      end else if (c < 88) begin
        add_header($urandom_range(1) ? TYPE_HANDSHAKE : TYPE_CCS, VER_MAJOR,
                   pick_minor(), 16'd0);
      end else if (c < 92) begin
        // length runs past the end of the packet
        add_header($urandom_range(1) ? TYPE_HANDSHAKE : TYPE_CCS, VER_MAJOR,
                   pick_minor(), 16'($urandom_range(41, 65535)));
        add_noise($urandom_range(0, 30));
      end else begin
        add_noise($urandom_range(1, 20));
      end
    end
    if ($urandom_range(99) < 6) add_noise($urandom_range(1, 13));
    if ($urandom_range(99) < 12 && pkt.size() > 1) begin
      n = $urandom_range(1, pkt.size() - 1);
      repeat (n) void'(pkt.pop_back());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int unsigned rnd_start;
    int unsigned done;
    bit          held;
    scb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // smallest valid handshake, packet ends on its last byte
    add_header(TYPE_HANDSHAKE, VER_MAJOR, VER_MINOR_A, 16'd12);
    add_hs_body(12, 24'd0);
    send_pkt();
    // completed change-cipher record, trailing bytes ignored
    add_header(TYPE_CCS, VER_MAJOR, VER_MINOR_B, 16'd1);
    pkt.push_back(8'h00);
    pkt.push_back(8'hff);
    send_pkt();
    pkt.push_back(8'hff);                                   // bad type
    send_pkt();
    pkt.push_back(TYPE_HANDSHAKE);                          // header cut after one byte
    send_pkt();
    pkt.push_back(TYPE_CCS);                                // bad major version
    pkt.push_back(8'h00);
    send_pkt();
    pkt.push_back(TYPE_HANDSHAKE);                          // bad minor version
    pkt.push_back(VER_MAJOR);
    pkt.push_back(8'hfe);
    send_pkt();
    add_header(TYPE_HANDSHAKE, VER_MAJOR, VER_MINOR_A, 16'd0);  // zero length
    send_pkt();
    add_header(TYPE_HANDSHAKE, VER_MAJOR, VER_MINOR_B, 16'd5);  // full header, no body
    send_pkt();
    add_header(TYPE_HANDSHAKE, VER_MAJOR, VER_MINOR_A, 16'd3);  // short handshake body
    add_hs_body(3, 24'd0);
    send_pkt();
    add_header(TYPE_HANDSHAKE, VER_MAJOR, VER_MINOR_A, 16'd16); // message length mismatch
    add_hs_body(16, 24'd5);
    send_pkt();
    add_header(TYPE_CCS, VER_MAJOR, VER_MINOR_A, 16'd4);        // change-cipher cut
    add_noise(2);
    send_pkt();
    // two handshake records, then a one-byte header tail
    add_header(TYPE_HANDSHAKE, VER_MAJOR, VER_MINOR_A, 16'd13);
    add_hs_body(13, 24'd1);
    add_header(TYPE_HANDSHAKE, VER_MAJOR, VER_MINOR_B, 16'd12);
    add_hs_body(12, 24'd0);
    pkt.push_back(TYPE_HANDSHAKE);
    send_pkt();

    rnd_start = sent_bytes;
    held      = 1'b0;
    while (sent_bytes - rnd_start < RANDOM_BYTES) begin
      done = sent_bytes - rnd_start;
      if (done > 600 && !held) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (done > 1100 && done < 1400) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 22;
        stall_pct = 22;
      end
      gen_packet();
      send_pkt();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (scb.pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (scb.pending_results.size() != 0)
      scb.report($sformatf("%0d results never arrived", scb.pending_results.size()));

    if (scb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dtlsrf_pkg.sv
hdl/dtlsrf_parse.sv
hdl/dtlsrf_outq.sv
hdl/dtls_record_framing_check.sv
dv/tb_dtls_record_framing_check.sv
